// ----- design/mfl_pkg.sv -----
// Shared types and constants of the max-flow level-graph engine.
// Depends on nothing; the top level imports it.
package mfl_pkg;

  localparam int MAX_V = 64;
  localparam int MAX_E = 256;
  localparam int CAP_W = 32;

  localparam int VW    = $clog2(MAX_V);       // vertex number
  localparam int NW    = VW + 1;              // vertex count, level, depth
  localparam int EW    = $clog2(MAX_E);       // edge number
  localparam int ECW   = EW + 1;              // edge count
  localparam int ENW   = EW + 1;              // adjacency entry: edge and reverse bit
  localparam int AW    = $clog2(2 * MAX_E);   // adjacency list index
  localparam int AC    = AW + 1;              // adjacency offset, up to the list size
  localparam int WQW   = (ENW > VW) ? ENW : VW;
  localparam int ER_W  = 2 * VW + CAP_W;
  localparam int TOT_W = 40;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_FLOW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_SRC = 2'd0;
  localparam logic [1:0] REG_SNK = 2'd1;
  localparam logic [1:0] REG_NV  = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [VW-1:0]    tail_vertex;
    logic [VW-1:0]    head_vertex;
    logic [CAP_W-1:0] edge_capacity;
    logic [CAP_W-1:0] initial_flow;
    logic [EW-1:0]    edge_index;
    logic             reset_flows;
  } mfl_in_t;

  typedef struct packed {
    logic [TOT_W-1:0] total_flow;
    logic [CAP_W-1:0] edge_flow;
    logic [ECW-1:0]   edge_total;
    logic [1:0]       status;
  } mfl_out_t;

  typedef struct packed {
    logic [VW-1:0]    tail;
    logic [VW-1:0]    head;
    logic [CAP_W-1:0] cap;
  } edge_rec_t;

endpackage

// ----- design/mfl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mfl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/max_flow_level_graph_engine_unit.sv -----
// Top level of the max-flow level-graph engine: command decode, edge store
// and the sequencer that runs the level and push phases. Uses mfl_pkg, mfl_ram.
//
//   channel  ports                          handshake
//   input    start, busy, in_word           taken when start is high and busy low
//   result   out_strobe, out_word           one cycle per word, cannot be held off
//   config   cfg_we, cfg_index, cfg_wdata   written on every edge with cfg_we high
//
// Add, clear and an out-of-range read answer in the next cycle; a read in range
// passes through S_RD_WAIT first. A compute is data dependent: the adjacency
// build pairs each vertex with each stored edge, then every phase adds a level
// pass and the depth-first pushes.
// busy stays high for the whole compute.
// Reset is synchronous and active low; the edge store needs no clearing pass.
module max_flow_level_graph_engine_unit import mfl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  mfl_in_t    in_word,
  output logic       out_strobe,
  output mfl_out_t   out_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam logic [5:0] S_IDLE = 6'd0,  S_RD_WAIT = 6'd1,  S_PRE_RD = 6'd2,
                         S_PRE_EX = 6'd3, S_CHK = 6'd4,    S_DONE = 6'd5,
                         S_CLR_FILL = 6'd6, S_CNT_RD = 6'd7, S_CNT_T = 6'd8,
                         S_CNT_TW = 6'd9, S_CNT_HR = 6'd10, S_CNT_HW = 6'd11,
                         S_PFX_RD = 6'd12, S_PFX_WR = 6'd13, S_BEG_END = 6'd14,
                         S_ADJ_RD = 6'd15, S_ADJ_CK = 6'd16, S_ADJ_F = 6'd17,
                         S_ADJ_HR = 6'd18, S_ADJ_H = 6'd19, S_LVL_INIT = 6'd20,
                         S_LVL_SRC = 6'd21, S_BFS_POP = 6'd22, S_BFS_U = 6'd23,
                         S_BFS_B0 = 6'd24, S_BFS_B1 = 6'd25, S_BFS_I = 6'd26,
                         S_BFS_ENT = 6'd27, S_BFS_ED = 6'd28, S_BFS_LV = 6'd29,
                         S_SNK_RD = 6'd30, S_SNK_CK = 6'd31, S_PTR_RD = 6'd32,
                         S_PTR_WR = 6'd33, S_AUG_START = 6'd34, S_AUG_ENTER = 6'd35,
                         S_AUG_LD = 6'd36, S_AUG_SCAN = 6'd37, S_AUG_ENT = 6'd38,
                         S_AUG_ED = 6'd39, S_AUG_LV = 6'd40, S_AUG_BACK = 6'd41,
                         S_AUG_POP = 6'd42, S_AUG_INC = 6'd43, S_PSH_INIT = 6'd44,
                         S_PSH_RD = 6'd45, S_PSH_ENT = 6'd46, S_PSH_ED = 6'd47,
                         S_UPD_RD = 6'd48, S_UPD_ENT = 6'd49, S_UPD_ED = 6'd50;

  // Control and configuration.
  logic [5:0]       state_r, state_nxt;
  logic [VW-1:0]    src_r, snk_r;
  logic [NW-1:0]    vc_r;
  logic [ECW-1:0]   stored_r, stored_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  mfl_out_t         out_word_r, out_word_nxt;

  // Sequencer working registers.
  logic [NW-1:0]    nv_r, nv_nxt;
  logic             zero_r, zero_nxt;
  logic [ECW-1:0]   e_r, e_nxt;
  logic [NW-1:0]    v_r, v_nxt;
  logic [AC-1:0]    acc_r, acc_nxt;
  logic [CAP_W-1:0] maxcap_r, maxcap_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [VW-1:0]    t_r, t_nxt, h_r, h_nxt;
  logic [NW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [VW-1:0]    u_r, u_nxt;
  logic [NW-1:0]    lvl_u_r, lvl_u_nxt;
  logic [AC-1:0]    i_r, i_nxt, iend_r, iend_nxt;
  logic [ENW-1:0]   ent_r, ent_nxt;
  logic [VW-1:0]    d_r, d_nxt;
  logic             rem_nz_r, rem_nz_nxt;
  logic [VW-1:0]    cur_r, cur_nxt;
  logic [NW-1:0]    depth_r, depth_nxt;
  logic [NW-1:0]    lvl_cur_r, lvl_cur_nxt;
  logic [AC-1:0]    ptr_r, ptr_nxt, pend_r, pend_nxt;
  logic [CAP_W-1:0] push_r, push_nxt;
  logic [NW-1:0]    k_r, k_nxt;

  // Memory ports.
  logic              em_we;
  logic [EW-1:0]     em_wa, em_ra;
  logic [ER_W-1:0]   em_wd, em_rd;
  logic              fm_we;
  logic [EW-1:0]     fm_wa;
  logic [CAP_W-1:0]  fm_wd, fm_rd;
  logic              fl_we;
  logic [VW-1:0]     fl_wa, fl_ra;
  logic [AC-1:0]     fl_wd, fl_rd;
  logic              bg_we;
  logic [NW-1:0]     bg_wa, bg_ra;
  logic [AC-1:0]     bg_wd, bg_rd;
  logic              aj_we;
  logic [AW-1:0]     aj_wa, aj_ra;
  logic [ENW-1:0]    aj_wd, aj_rd;
  logic              lv_we;
  logic [VW-1:0]     lv_wa, lv_ra;
  logic [NW-1:0]     lv_wd, lv_rd;
  logic              pt_we;
  logic [VW-1:0]     pt_wa, pt_ra;
  logic [AC-1:0]     pt_wd, pt_rd;
  logic              wq_we;
  logic [VW-1:0]     wq_wa, wq_ra;
  logic [WQW-1:0]    wq_wd, wq_rd;
  logic              pa_we;
  logic [NW-1:0]     pa_wa, pa_ra;
  logic [VW-1:0]     pa_wd, pa_rd;

  edge_rec_t         ed;
  logic              usable;
  logic [VW-1:0]     dest;
  logic [CAP_W-1:0]  rem;
  logic [NW-1:0]     nv_in;
  logic [CAP_W-1:0]  add_flow;
  logic [TOT_W:0]    sum;

  assign ed     = edge_rec_t'(em_rd);
  assign usable = ({1'b0, ed.tail} < nv_r) && ({1'b0, ed.head} < nv_r);
  assign dest   = ent_r[0] ? ed.tail : ed.head;
  assign rem    = ent_r[0] ? fm_rd : (ed.cap - fm_rd);
  assign sum    = {1'b0, total_r} + (TOT_W+1)'(push_r);

  assign nv_in    = (vc_r == '0) ? NW'(1) : ((vc_r > NW'(MAX_V)) ? NW'(MAX_V) : vc_r);
  assign add_flow = (in_word.initial_flow > in_word.edge_capacity) ?
                    in_word.edge_capacity : in_word.initial_flow;

  mfl_ram #(.W(ER_W), .D(MAX_E)) u_edge_ram (
    .clk, .we(em_we), .waddr(em_wa), .wdata(em_wd), .raddr(em_ra), .rdata(em_rd));
  mfl_ram #(.W(CAP_W), .D(MAX_E)) u_flow_ram (
    .clk, .we(fm_we), .waddr(fm_wa), .wdata(fm_wd), .raddr(em_ra), .rdata(fm_rd));
  mfl_ram #(.W(AC), .D(MAX_V)) u_fill_ram (
    .clk, .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
  mfl_ram #(.W(AC), .D(MAX_V + 1)) u_begin_ram (
    .clk, .we(bg_we), .waddr(bg_wa), .wdata(bg_wd), .raddr(bg_ra), .rdata(bg_rd));
  mfl_ram #(.W(ENW), .D(2 * MAX_E)) u_adj_ram (
    .clk, .we(aj_we), .waddr(aj_wa), .wdata(aj_wd), .raddr(aj_ra), .rdata(aj_rd));
  mfl_ram #(.W(NW), .D(MAX_V)) u_level_ram (
    .clk, .we(lv_we), .waddr(lv_wa), .wdata(lv_wd), .raddr(lv_ra), .rdata(lv_rd));
  mfl_ram #(.W(AC), .D(MAX_V)) u_ptr_ram (
    .clk, .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd));
  mfl_ram #(.W(WQW), .D(MAX_V)) u_work_ram (
    .clk, .we(wq_we), .waddr(wq_wa), .wdata(wq_wd), .raddr(wq_ra), .rdata(wq_rd));
  mfl_ram #(.W(VW), .D(MAX_V + 1)) u_path_ram (
    .clk, .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .raddr(pa_ra), .rdata(pa_rd));

  always_comb begin
    state_nxt      = state_r;
    stored_nxt     = stored_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    nv_nxt         = nv_r;
    zero_nxt       = zero_r;
    e_nxt          = e_r;
    v_nxt          = v_r;
    acc_nxt        = acc_r;
    maxcap_nxt     = maxcap_r;
    total_nxt      = total_r;
    t_nxt          = t_r;
    h_nxt          = h_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    u_nxt          = u_r;
    lvl_u_nxt      = lvl_u_r;
    i_nxt          = i_r;
    iend_nxt       = iend_r;
    ent_nxt        = ent_r;
    d_nxt          = d_r;
    rem_nz_nxt     = rem_nz_r;
    cur_nxt        = cur_r;
    depth_nxt      = depth_r;
    lvl_cur_nxt    = lvl_cur_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    push_nxt       = push_r;
    k_nxt          = k_r;

    em_we = 1'b0; em_wa = stored_r[EW-1:0]; em_wd = '0; em_ra = e_r[EW-1:0];
    fm_we = 1'b0; fm_wa = e_r[EW-1:0];      fm_wd = '0;
    fl_we = 1'b0; fl_wa = v_r[VW-1:0];      fl_wd = '0; fl_ra = v_r[VW-1:0];
    bg_we = 1'b0; bg_wa = v_r;              bg_wd = acc_r; bg_ra = v_r;
    aj_we = 1'b0; aj_wa = fl_rd[AW-1:0];    aj_wd = '0; aj_ra = i_r[AW-1:0];
    lv_we = 1'b0; lv_wa = v_r[VW-1:0];      lv_wd = '0; lv_ra = cur_r;
    pt_we = 1'b0; pt_wa = cur_r;            pt_wd = ptr_r; pt_ra = cur_r;
    wq_we = 1'b0; wq_wa = depth_r[VW-1:0];  wq_wd = '0; wq_ra = k_r[VW-1:0];
    pa_we = 1'b0; pa_wa = depth_r;          pa_wd = '0; pa_ra = depth_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_word_nxt.total_flow = '0;
          out_word_nxt.edge_flow  = '0;
          out_word_nxt.edge_total = stored_r;
          out_word_nxt.status     = ST_OK;
          case (in_word.command)
            CMD_ADD: begin
              out_strobe_nxt = 1'b1;
              if (stored_r >= ECW'(MAX_E)) begin
                out_word_nxt.status = ST_FULL;
              end else begin
                em_we = 1'b1;
                em_wd = {in_word.tail_vertex, in_word.head_vertex, in_word.edge_capacity};
                fm_we = 1'b1;
                fm_wa = stored_r[EW-1:0];
                fm_wd = add_flow;
                stored_nxt = stored_r + ECW'(1);
                out_word_nxt.edge_total = stored_r + ECW'(1);
              end
            end
            CMD_FLOW: begin
              nv_nxt     = nv_in;
              zero_nxt   = in_word.reset_flows;
              e_nxt      = '0;
              maxcap_nxt = '0;
              total_nxt  = '0;
              state_nxt  = S_PRE_RD;
            end
            CMD_READ: begin
              em_ra = in_word.edge_index;
              if ({1'b0, in_word.edge_index} < stored_r) begin
                state_nxt = S_RD_WAIT;
              end else begin
                out_strobe_nxt      = 1'b1;
                out_word_nxt.status = ST_RANGE;
              end
            end
            default: begin
              stored_nxt              = '0;
              out_word_nxt.edge_total = '0;
              out_strobe_nxt          = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        out_word_nxt.edge_flow = fm_rd;
        out_strobe_nxt         = 1'b1;
        state_nxt              = S_IDLE;
      end

      // Optional flow reset and search for the largest capacity.
      S_PRE_RD: begin
        state_nxt = (e_r == stored_r) ? S_CHK : S_PRE_EX;
      end
      S_PRE_EX: begin
        if (usable) begin
          fm_we = zero_r;
          if (ed.cap > maxcap_r) begin
            maxcap_nxt = ed.cap;
          end
        end
        e_nxt     = e_r + ECW'(1);
        state_nxt = S_PRE_RD;
      end
      S_CHK: begin
        v_nxt = '0;
        if ({1'b0, src_r} >= nv_r || {1'b0, snk_r} >= nv_r || src_r == snk_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CLR_FILL;
        end
      end
      S_DONE: begin
        out_word_nxt.total_flow = total_r;
        out_strobe_nxt          = 1'b1;
        state_nxt               = S_IDLE;
      end

      // Adjacency build: count entries per vertex.
      S_CLR_FILL: begin
        fl_we = 1'b1;
        e_nxt = '0;
        if (v_r == nv_r - NW'(1)) begin
          state_nxt = S_CNT_RD;
        end else begin
          v_nxt = v_r + NW'(1);
        end
      end
      S_CNT_RD: begin
        if (e_r == stored_r) begin
          v_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_PFX_RD;
        end else begin
          state_nxt = S_CNT_T;
        end
      end
      S_CNT_T: begin
        t_nxt = ed.tail;
        h_nxt = ed.head;
        fl_ra = ed.tail;
        if (usable) begin
          state_nxt = S_CNT_TW;
        end else begin
          e_nxt     = e_r + ECW'(1);
          state_nxt = S_CNT_RD;
        end
      end
      S_CNT_TW: begin
        fl_we     = 1'b1;
        fl_wa     = t_r;
        fl_wd     = fl_rd + AC'(1);
        state_nxt = S_CNT_HR;
      end
      S_CNT_HR: begin
        fl_ra     = h_r;
        state_nxt = S_CNT_HW;
      end
      S_CNT_HW: begin
        fl_we     = 1'b1;
        fl_wa     = h_r;
        fl_wd     = fl_rd + AC'(1);
        e_nxt     = e_r + ECW'(1);
        state_nxt = S_CNT_RD;
      end

      // Running sum gives each vertex its list start; fill becomes a write cursor.
      S_PFX_RD: begin
        state_nxt = S_PFX_WR;
      end
      S_PFX_WR: begin
        bg_we   = 1'b1;
        fl_we   = 1'b1;
        fl_wd   = acc_r;
        acc_nxt = acc_r + fl_rd;
        if (v_r == nv_r - NW'(1)) begin
          state_nxt = S_BEG_END;
        end else begin
          v_nxt     = v_r + NW'(1);
          state_nxt = S_PFX_RD;
        end
      end
      S_BEG_END: begin
        bg_we     = 1'b1;
        bg_wa     = nv_r;
        v_nxt     = '0;
        e_nxt     = '0;
        state_nxt = S_ADJ_RD;
      end

      // Place forward entries by tail, reverse entries on the head's list.
      S_ADJ_RD: begin
        if (e_r == stored_r) begin
          e_nxt = '0;
          if (v_r == nv_r - NW'(1)) begin
            v_nxt     = '0;
            state_nxt = S_LVL_INIT;
          end else begin
            v_nxt = v_r + NW'(1);
          end
        end else begin
          state_nxt = S_ADJ_CK;
        end
      end
      S_ADJ_CK: begin
        h_nxt = ed.head;
        if (usable && {1'b0, ed.tail} == v_r) begin
          state_nxt = S_ADJ_F;
        end else begin
          e_nxt     = e_r + ECW'(1);
          state_nxt = S_ADJ_RD;
        end
      end
      S_ADJ_F: begin
        aj_we     = 1'b1;
        aj_wd     = {e_r[EW-1:0], 1'b0};
        fl_we     = 1'b1;
        fl_wd     = fl_rd + AC'(1);
        state_nxt = S_ADJ_HR;
      end
      S_ADJ_HR: begin
        fl_ra     = h_r;
        state_nxt = S_ADJ_H;
      end
      S_ADJ_H: begin
        aj_we     = 1'b1;
        aj_wd     = {e_r[EW-1:0], 1'b1};
        fl_we     = 1'b1;
        fl_wa     = h_r;
        fl_wd     = fl_rd + AC'(1);
        e_nxt     = e_r + ECW'(1);
        state_nxt = S_ADJ_RD;
      end

      // Breadth-first level pass.
      S_LVL_INIT: begin
        lv_we = 1'b1;
        lv_wd = nv_r + NW'(1);
        if (v_r == nv_r - NW'(1)) begin
          state_nxt = S_LVL_SRC;
        end else begin
          v_nxt = v_r + NW'(1);
        end
      end
      S_LVL_SRC: begin
        lv_we     = 1'b1;
        lv_wa     = src_r;
        lv_wd     = '0;
        wq_we     = 1'b1;
        wq_wa     = '0;
        wq_wd     = WQW'(src_r);
        head_nxt  = '0;
        tail_nxt  = NW'(1);
        state_nxt = S_BFS_POP;
      end
      S_BFS_POP: begin
        wq_ra = head_r[VW-1:0];
        if (head_r == tail_r) begin
          state_nxt = S_SNK_RD;
        end else begin
          head_nxt  = head_r + NW'(1);
          state_nxt = S_BFS_U;
        end
      end
      S_BFS_U: begin
        u_nxt     = wq_rd[VW-1:0];
        lv_ra     = wq_rd[VW-1:0];
        bg_ra     = {1'b0, wq_rd[VW-1:0]};
        state_nxt = S_BFS_B0;
      end
      S_BFS_B0: begin
        lvl_u_nxt = lv_rd;
        i_nxt     = bg_rd;
        bg_ra     = {1'b0, u_r} + NW'(1);
        state_nxt = S_BFS_B1;
      end
      S_BFS_B1: begin
        iend_nxt  = bg_rd;
        state_nxt = S_BFS_I;
      end
      S_BFS_I: begin
        state_nxt = (i_r == iend_r) ? S_BFS_POP : S_BFS_ENT;
      end
      S_BFS_ENT: begin
        ent_nxt   = aj_rd;
        em_ra     = aj_rd[ENW-1:1];
        state_nxt = S_BFS_ED;
      end
      S_BFS_ED: begin
        d_nxt      = dest;
        rem_nz_nxt = (rem != '0);
        lv_ra      = dest;
        state_nxt  = S_BFS_LV;
      end
      S_BFS_LV: begin
        if (rem_nz_r && lv_rd == nv_r + NW'(1) && tail_r < nv_r) begin
          lv_we    = 1'b1;
          lv_wa    = d_r;
          lv_wd    = lvl_u_r + NW'(1);
          wq_we    = 1'b1;
          wq_wa    = tail_r[VW-1:0];
          wq_wd    = WQW'(d_r);
          tail_nxt = tail_r + NW'(1);
        end
        i_nxt     = i_r + AC'(1);
        state_nxt = S_BFS_I;
      end
      S_SNK_RD: begin
        lv_ra     = snk_r;
        state_nxt = S_SNK_CK;
      end
      S_SNK_CK: begin
        v_nxt     = '0;
        state_nxt = (lv_rd == nv_r + NW'(1)) ? S_DONE : S_PTR_RD;
      end
      S_PTR_RD: begin
        state_nxt = S_PTR_WR;
      end
      S_PTR_WR: begin
        pt_we = 1'b1;
        pt_wa = v_r[VW-1:0];
        pt_wd = bg_rd;
        if (v_r == nv_r - NW'(1)) begin
          state_nxt = S_AUG_START;
        end else begin
          v_nxt     = v_r + NW'(1);
          state_nxt = S_PTR_RD;
        end
      end

      // Depth-first augmentation along rising levels.
      S_AUG_START: begin
        depth_nxt = '0;
        cur_nxt   = src_r;
        pa_we     = 1'b1;
        pa_wa     = '0;
        pa_wd     = src_r;
        state_nxt = S_AUG_ENTER;
      end
      S_AUG_ENTER: begin
        bg_ra     = {1'b0, cur_r} + NW'(1);
        state_nxt = (cur_r == snk_r) ? S_PSH_INIT : S_AUG_LD;
      end
      S_AUG_LD: begin
        lvl_cur_nxt = lv_rd;
        ptr_nxt     = pt_rd;
        pend_nxt    = bg_rd;
        state_nxt   = S_AUG_SCAN;
      end
      S_AUG_SCAN: begin
        aj_ra     = ptr_r[AW-1:0];
        state_nxt = (ptr_r < pend_r) ? S_AUG_ENT : S_AUG_BACK;
      end
      S_AUG_ENT: begin
        ent_nxt   = aj_rd;
        em_ra     = aj_rd[ENW-1:1];
        state_nxt = S_AUG_ED;
      end
      S_AUG_ED: begin
        d_nxt      = dest;
        rem_nz_nxt = (rem != '0);
        lv_ra      = dest;
        state_nxt  = S_AUG_LV;
      end
      S_AUG_LV: begin
        if (rem_nz_r && lvl_cur_r < lv_rd && depth_r < nv_r) begin
          wq_we     = 1'b1;
          wq_wd     = WQW'(ent_r);
          pa_we     = 1'b1;
          pa_wa     = depth_r + NW'(1);
          pa_wd     = d_r;
          pt_we     = 1'b1;
          depth_nxt = depth_r + NW'(1);
          cur_nxt   = d_r;
          state_nxt = S_AUG_ENTER;
        end else begin
          ptr_nxt   = ptr_r + AC'(1);
          state_nxt = S_AUG_SCAN;
        end
      end
      S_AUG_BACK: begin
        pt_we = 1'b1;
        if (depth_r == '0) begin
          // No path left in this level graph: build the next one.
          v_nxt     = '0;
          state_nxt = S_LVL_INIT;
        end else begin
          depth_nxt = depth_r - NW'(1);
          pa_ra     = depth_r - NW'(1);
          state_nxt = S_AUG_POP;
        end
      end
      S_AUG_POP: begin
        cur_nxt   = pa_rd;
        pt_ra     = pa_rd;
        state_nxt = S_AUG_INC;
      end
      S_AUG_INC: begin
        pt_we     = 1'b1;
        pt_wd     = pt_rd + AC'(1);
        state_nxt = S_AUG_ENTER;
      end

      // Bottleneck over the path, then apply it.
      S_PSH_INIT: begin
        push_nxt  = maxcap_r;
        k_nxt     = '0;
        state_nxt = S_PSH_RD;
      end
      S_PSH_RD: begin
        if (k_r == depth_r) begin
          k_nxt     = '0;
          state_nxt = S_UPD_RD;
        end else begin
          state_nxt = S_PSH_ENT;
        end
      end
      S_PSH_ENT: begin
        ent_nxt   = wq_rd[ENW-1:0];
        em_ra     = wq_rd[ENW-1:1];
        state_nxt = S_PSH_ED;
      end
      S_PSH_ED: begin
        if (rem < push_r) begin
          push_nxt = rem;
        end
        k_nxt     = k_r + NW'(1);
        state_nxt = S_PSH_RD;
      end
      S_UPD_RD: begin
        if (k_r == depth_r) begin
          total_nxt = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
          state_nxt = S_AUG_START;
        end else begin
          state_nxt = S_UPD_ENT;
        end
      end
      S_UPD_ENT: begin
        ent_nxt   = wq_rd[ENW-1:0];
        em_ra     = wq_rd[ENW-1:1];
        state_nxt = S_UPD_ED;
      end
      S_UPD_ED: begin
        fm_we     = 1'b1;
        fm_wa     = ent_r[ENW-1:1];
        fm_wd     = ent_r[0] ? (fm_rd - push_r) : (fm_rd + push_r);
        k_nxt     = k_r + NW'(1);
        state_nxt = S_UPD_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      stored_r     <= '0;
      out_strobe_r <= 1'b0;
      src_r        <= '0;
      snk_r        <= VW'(63);
      vc_r         <= NW'(64);
    end else begin
      state_r      <= state_nxt;
      stored_r     <= stored_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SRC: src_r <= cfg_wdata[VW-1:0];
          REG_SNK: snk_r <= cfg_wdata[VW-1:0];
          REG_NV:  vc_r  <= cfg_wdata[NW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    nv_r       <= nv_nxt;
    zero_r     <= zero_nxt;
    e_r        <= e_nxt;
    v_r        <= v_nxt;
    acc_r      <= acc_nxt;
    maxcap_r   <= maxcap_nxt;
    total_r    <= total_nxt;
    t_r        <= t_nxt;
    h_r        <= h_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    u_r        <= u_nxt;
    lvl_u_r    <= lvl_u_nxt;
    i_r        <= i_nxt;
    iend_r     <= iend_nxt;
    ent_r      <= ent_nxt;
    d_r        <= d_nxt;
    rem_nz_r   <= rem_nz_nxt;
    cur_r      <= cur_nxt;
    depth_r    <= depth_nxt;
    lvl_cur_r  <= lvl_cur_nxt;
    ptr_r      <= ptr_nxt;
    pend_r     <= pend_nxt;
    push_r     <= push_nxt;
    k_r        <= k_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

`ifndef SYNTHESIS
  // A result word is only shown once the sequencer is back at rest.
  ap_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == S_IDLE))
    else $error("result word while sequencer busy");

  ap_stored_max: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= ECW'(MAX_E))
    else $error("edge count above store size");

  ap_flow_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.command == CMD_FLOW) |=> busy)
    else $error("compute command did not start the sequencer");

  ap_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AUG_LV || state_r == S_AUG_SCAN) |-> (depth_r <= nv_r))
    else $error("augmenting path deeper than vertex count");

  ap_queue_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BFS_LV || state_r == S_BFS_POP) |-> (tail_r <= nv_r && head_r <= tail_r))
    else $error("level queue pointers out of order");
`endif

endmodule

// ----- bench/max_flow_level_graph_engine_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for max_flow_level_graph_engine_unit: directed and random command
// words checked against a built-in Dinic flow predictor. Depends on mfl_pkg and the top.
module max_flow_level_graph_engine_unit_test;
  import mfl_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  mfl_in_t in_word = '0;
  logic out_strobe;
  mfl_out_t out_word;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_SRC;
  logic [6:0] cfg_wdata = '0;

  max_flow_level_graph_engine_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mfl_in_t pending_words[$];
  mfl_out_t expected_words[$];
  int idle_pct = 0;
  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int computes_sent = 0;

  // Shadow state of the engine.
  int unsigned src_v = 0, snk_v = 63, nv_reg = 64;
  int unsigned e_tail[MAX_E], e_head[MAX_E];
  longint unsigned e_cap[MAX_E], e_flow[MAX_E];
  int unsigned n_edges = 0;
  int unsigned adj_beg[MAX_V+1], adj_fil[MAX_V], adj_lst[2*MAX_E];
  int unsigned lvl[MAX_V], cur_ptr[MAX_V], work_q[MAX_V], path_v[MAX_V+1];

  function automatic bit edge_in_graph(int unsigned e, int unsigned nv);
    return e_tail[e] < nv && e_head[e] < nv;
  endfunction

  function automatic int unsigned entry_to(int unsigned ent);
    return ent[0] ? e_tail[ent >> 1] : e_head[ent >> 1];
  endfunction

  function automatic longint unsigned residual(int unsigned ent);
    return ent[0] ? e_flow[ent >> 1] : e_cap[ent >> 1] - e_flow[ent >> 1];
  endfunction

  function automatic void build_lists(int unsigned nv);
    int unsigned acc;
    acc = 0;
    for (int unsigned v = 0; v < nv; v++) adj_fil[v] = 0;
    for (int unsigned e = 0; e < n_edges; e++)
      if (edge_in_graph(e, nv)) begin
        adj_fil[e_tail[e]]++;
        adj_fil[e_head[e]]++;
      end
    for (int unsigned v = 0; v < nv; v++) begin
      adj_beg[v] = acc;
      acc += adj_fil[v];
      adj_fil[v] = adj_beg[v];
    end
    adj_beg[nv] = acc;
    for (int unsigned v = 0; v < nv; v++)
      for (int unsigned e = 0; e < n_edges; e++)
        if (e_tail[e] == v && edge_in_graph(e, nv)) begin
          adj_lst[adj_fil[v]++] = e * 2;
          adj_lst[adj_fil[e_head[e]]++] = e * 2 + 1;
        end
  endfunction

  function automatic void assign_levels(int unsigned nv);
    int unsigned qh, qt, u, d, ent;
    qh = 0;
    qt = 0;
    for (int unsigned v = 0; v < nv; v++) lvl[v] = nv + 1;
    lvl[src_v] = 0;
    work_q[qt++] = src_v;
    while (qh < qt) begin
      u = work_q[qh++];
      for (int unsigned i = adj_beg[u]; i < adj_beg[u+1]; i++) begin
        ent = adj_lst[i];
        d = entry_to(ent);
        if (residual(ent) > 0 && lvl[d] == nv + 1 && qt < nv) begin
          lvl[d] = lvl[u] + 1;
          work_q[qt++] = d;
        end
      end
    end
  endfunction

  // One depth-first push along the level graph; returns the amount pushed.
  function automatic longint unsigned push_one_path(int unsigned nv, longint unsigned bound);
    int unsigned depth, at, ent, d;
    longint unsigned amt;
    bit found;
    depth = 0;
    at = src_v;
    path_v[0] = src_v;
    forever begin
      if (at == snk_v) begin
        amt = bound;
        for (int unsigned k = 0; k < depth; k++)
          if (residual(work_q[k]) < amt) amt = residual(work_q[k]);
        for (int unsigned k = 0; k < depth; k++) begin
          ent = work_q[k];
          if (ent[0]) e_flow[ent >> 1] -= amt;
          else e_flow[ent >> 1] += amt;
        end
        return amt;
      end
      found = 0;
      while (cur_ptr[at] < adj_beg[at+1]) begin
        ent = adj_lst[cur_ptr[at]];
        d = entry_to(ent);
        if (residual(ent) > 0 && lvl[at] < lvl[d] && depth < nv) begin
          work_q[depth++] = ent;
          path_v[depth] = d;
          at = d;
          found = 1;
          break;
        end
        cur_ptr[at]++;
      end
      if (!found) begin
        if (depth == 0) return 0;
        depth--;
        at = path_v[depth];
        cur_ptr[at]++;
      end
    end
  endfunction

  function automatic logic [TOT_W-1:0] dinic_total(bit zero_flows);
    int unsigned nv;
    longint unsigned top_cap, sum, amt;
    nv = nv_reg;
    top_cap = 0;
    sum = 0;
    if (nv == 0) nv = 1;
    if (nv > MAX_V) nv = MAX_V;
    for (int unsigned e = 0; e < n_edges; e++)
      if (edge_in_graph(e, nv)) begin
        if (zero_flows) e_flow[e] = 0;
        if (e_cap[e] > top_cap) top_cap = e_cap[e];
      end
    if (src_v >= nv || snk_v >= nv || src_v == snk_v) return '0;
    build_lists(nv);
    forever begin
      assign_levels(nv);
      if (lvl[snk_v] == nv + 1) break;
      for (int unsigned v = 0; v < nv; v++) cur_ptr[v] = adj_beg[v];
      do begin
        amt = push_one_path(nv, top_cap);
        sum += amt;
      end while (amt > 0);
    end
    return (sum > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : sum[TOT_W-1:0];
  endfunction

  function automatic mfl_out_t apply_command(mfl_in_t w);
    mfl_out_t r;
    r = '0;
    case (w.command)
      CMD_ADD: begin
        if (n_edges >= MAX_E) r.status = ST_FULL;
        else begin
          e_tail[n_edges] = w.tail_vertex;
          e_head[n_edges] = w.head_vertex;
          e_cap[n_edges] = w.edge_capacity;
          e_flow[n_edges] = (w.initial_flow > w.edge_capacity) ? w.edge_capacity
                                                                : w.initial_flow;
          n_edges++;
        end
      end
      CMD_FLOW: r.total_flow = dinic_total(w.reset_flows);
      CMD_READ: begin
        if (w.edge_index < n_edges) r.edge_flow = e_flow[w.edge_index][CAP_W-1:0];
        else r.status = ST_RANGE;
      end
      default: n_edges = 0;
    endcase
    r.edge_total = n_edges[ECW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch on word %0d: %s got %0h expected %0h", words_seen, what, got, want);
    errors++;
  endtask

  // Sender: a word is taken at an edge where start is high and busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_words.push_back(apply_command(in_word));
        words_sent++;
        if (in_word.command == CMD_FLOW) computes_sent++;
      end
      if (!start || !busy) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_word <= pending_words.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result side: every strobed word is compared with the oldest expectation.
  always @(posedge clk) begin
    mfl_out_t want;
    if (rst_n && out_strobe) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("unexpected result word %0h", out_word);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (out_word.total_flow !== want.total_flow)
          report_mismatch("total_flow", out_word.total_flow, want.total_flow);
        if (out_word.edge_flow !== want.edge_flow)
          report_mismatch("edge_flow", out_word.edge_flow, want.edge_flow);
        if (out_word.edge_total !== want.edge_total)
          report_mismatch("edge_total", out_word.edge_total, want.edge_total);
        if (out_word.status !== want.status)
          report_mismatch("status", out_word.status, want.status);
      end
    end
  end

  function automatic mfl_in_t make_word(logic [1:0] cmd, int unsigned t, int unsigned h,
                                        logic [31:0] cap, logic [31:0] fl,
                                        int unsigned idx, int unsigned zero);
    mfl_in_t w;
    w.command = cmd;
    w.tail_vertex = VW'(t);
    w.head_vertex = VW'(h);
    w.edge_capacity = cap;
    w.initial_flow = fl;
    w.edge_index = EW'(idx);
    w.reset_flows = zero[0];
    return w;
  endfunction

  // The last word may still sit in the sender when the queue runs empty, so check again after a wait.
  task automatic wait_drained();
    do begin
      wait (pending_words.size() == 0 && !start && expected_words.size() == 0 && !busy);
      repeat (8) @(posedge clk);
    end while (pending_words.size() != 0 || start || expected_words.size() != 0 || busy);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 7'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SRC: src_v = val & 63;
      REG_SNK: snk_v = val & 63;
      default: nv_reg = val & 127;
    endcase
  endtask

  // A random word; vertices mostly inside the graph so flows are nontrivial.
  function automatic mfl_in_t random_word(int unsigned nv);
    int unsigned pick, lim;
    logic [31:0] cap;
    pick = $urandom_range(99);
    lim = (nv == 0) ? 0 : ((nv > MAX_V) ? MAX_V - 1 : nv - 1);
    cap = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
    if (pick < 55)
      return make_word(CMD_ADD,
                       ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(lim),
                       ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(lim),
                       cap, ($urandom_range(2) == 0) ? $urandom : $urandom_range(cap),
                       $urandom, $urandom);
    if (pick < 78)
      return make_word(CMD_FLOW, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (pick < 96)
      return make_word(CMD_READ, $urandom, $urandom, $urandom, $urandom,
                       ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(20),
                       $urandom);
    return make_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  initial begin
    int unsigned nv;
    int phase_idle[4];
    phase_idle = '{0, 54, 21, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, clamping, self loop, out-of-graph edge, every command.
    pending_words.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 0, 5, 32'hFFFF_FFFF, 32'h0, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 5, 63, 32'd7, 32'hFFFF_FFFF, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 0, 63, 32'h0, 32'h0, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 5, 5, 32'd9, 32'd3, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 0, 63, 32'h8000_0000, 32'h1234, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 63, 0, 32'd100, 32'd50, 0, 0));
    pending_words.push_back(make_word(CMD_FLOW, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_READ, 0, 0, 0, 0, 1, 0));
    pending_words.push_back(make_word(CMD_READ, 0, 0, 0, 0, 4, 0));
    pending_words.push_back(make_word(CMD_FLOW, 0, 0, 0, 0, 0, 1));
    pending_words.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_READ, 0, 0, 0, 0, 255, 0));
    wait_drained();
    write_reg(REG_NV, 0);
    pending_words.push_back(make_word(CMD_FLOW, 0, 0, 0, 0, 0, 1));
    wait_drained();
    write_reg(REG_NV, 127);
    write_reg(REG_SNK, 0);
    pending_words.push_back(make_word(CMD_FLOW, 0, 0, 0, 0, 0, 0));
    wait_drained();
    write_reg(REG_SRC, 63);
    write_reg(REG_SNK, 5);
    write_reg(REG_NV, 6);
    pending_words.push_back(make_word(CMD_FLOW, 0, 0, 0, 0, 0, 1));
    pending_words.push_back(make_word(CMD_READ, 0, 0, 0, 0, 2, 0));
    pending_words.push_back(make_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Random phases, each with its own register setting and sender idling.
    for (int p = 0; p < 4; p++) begin
      nv = (p == 3) ? 64 : $urandom_range(3, 12);
      write_reg(REG_NV, nv);
      write_reg(REG_SRC, $urandom_range(nv - 1));
      write_reg(REG_SNK, ($urandom_range(7) == 0) ? $urandom_range(63)
                                                  : $urandom_range(nv - 1));
      idle_pct = phase_idle[p];
      pending_words.push_back(make_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 20; i++) pending_words.push_back(random_word(nv));
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0d result words never arrived", expected_words.size());
      errors += expected_words.size();
    end
    $display("Sent %0d command words (%0d flow computes), checked %0d result words.",
             words_sent, computes_sent, words_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
